// ----- rtl/mwm_pkg.sv -----
// Shared types and constants of the mecanum wheel mixer.
package mwm_pkg;
   localparam int unsigned WheelCount = 4;
   localparam int unsigned VelWidth = 16;
   localparam int unsigned RatioWidth = 18;
   localparam int unsigned MagWidth = 17;
   localparam int unsigned ScaleWidth = 8;
   localparam int unsigned GainWidth = 15;
   localparam int unsigned ProdWidth = MagWidth + ScaleWidth;
   localparam int unsigned FullWidth = ProdWidth + GainWidth;
   localparam int unsigned GainFrac = 14;
   localparam int unsigned NumWidth = FullWidth - GainFrac;
   localparam int unsigned SpeedWidth = 8;
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth = 15;

   localparam logic [MagWidth-1:0] OneQ13 = 17'd8192;
   localparam logic [SpeedWidth-1:0] SpeedMax = 8'd255;
   localparam logic [ScaleWidth-1:0] ScaleReset = 8'd128;
   localparam logic [GainWidth-1:0] GainReset = 15'd16384;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_SPEED_SCALE = 3'd0,
      CSR_GAIN_FL     = 3'd1,
      CSR_GAIN_FR     = 3'd2,
      CSR_GAIN_RL     = 3'd3,
      CSR_GAIN_RR     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [ScaleWidth-1:0] scale;
      logic [WheelCount-1:0][GainWidth-1:0] gain;
   } cfg_type;

   // One mixed command waiting for division.
   typedef struct packed {
      logic [WheelCount-1:0][NumWidth-1:0] num;
      logic [MagWidth-1:0] den;
      logic [WheelCount-1:0] fwd;
   } job_type;
endpackage

// ----- rtl/mwm_if.sv -----
// Request and response channel interfaces of the mecanum wheel mixer.
interface mwm_req_if;
   logic valid;
   logic ready;
   logic signed [15:0] vel_x;
   logic signed [15:0] vel_y;
   logic signed [15:0] turn_rate;
   modport source (output valid, vel_x, vel_y, turn_rate, input ready);
   modport sink (input valid, vel_x, vel_y, turn_rate, output ready);
endinterface

interface mwm_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] fl_speed;
   logic fl_forward;
   logic [7:0] fr_speed;
   logic fr_forward;
   logic [7:0] rl_speed;
   logic rl_forward;
   logic [7:0] rr_speed;
   logic rr_forward;
   modport source (output valid, fl_speed, fl_forward, fr_speed, fr_forward,
                   rl_speed, rl_forward, rr_speed, rr_forward, input ready);
   modport sink (input valid, fl_speed, fl_forward, fr_speed, fr_forward,
                 rl_speed, rl_forward, rr_speed, rr_forward, output ready);
endinterface

// ----- rtl/mwm_front.sv -----
// Front pipeline: mix the request into wheel ratios, find the divisor, scale, apply the wheel gains.
module mwm_front (
   input  logic            clock,
   input  logic            reset,
   mwm_req_if.sink         req_chan,
   input  mwm_pkg::cfg_type cfg,
   output logic            job_valid,
   input  logic            job_ready,
   output mwm_pkg::job_type job
);
   import mwm_pkg::*;

   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3;
   logic signed [WheelCount-1:0][RatioWidth-1:0] ratio_ff, ratio_in;
   logic [WheelCount-1:0][ProdWidth-1:0] prod_ff, prod_in;
   logic [MagWidth-1:0] den2_ff, den2_in, den3_ff;
   logic [WheelCount-1:0] fwd2_ff, fwd2_in, fwd3_ff;
   logic [WheelCount-1:0][NumWidth-1:0] num_ff, num_in;
   logic [WheelCount-1:0][MagWidth-1:0] mag;
   logic [MagWidth-1:0] mx;
   logic signed [RatioWidth-1:0] x, y, w;
   logic [FullWidth-1:0] full;

   assign en3 = !v3_ff || job_ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_chan.ready = en1;

   always_comb begin
      x = RatioWidth'(req_chan.vel_x);
      y = RatioWidth'(req_chan.vel_y);
      w = RatioWidth'(req_chan.turn_rate);
      ratio_in[0] = -x - y - w;
      ratio_in[1] = -x + y - w;
      ratio_in[2] = x - y - w;
      ratio_in[3] = x + y - w;
   end

   always_comb begin
      mx = '0;
      for (int i = 0; i < WheelCount; i++) begin
         mag[i] = ratio_ff[i][RatioWidth-1] ? MagWidth'(-ratio_ff[i])
                                            : MagWidth'(ratio_ff[i]);
         prod_in[i] = ProdWidth'(mag[i]) * ProdWidth'(cfg.scale);
         fwd2_in[i] = !ratio_ff[i][RatioWidth-1] && (ratio_ff[i] != '0);
         if (mag[i] > mx) begin
            mx = mag[i];
         end
      end
      den2_in = (mx > OneQ13) ? mx : OneQ13;
   end

   always_comb begin
      full = '0;
      for (int i = 0; i < WheelCount; i++) begin
         full = FullWidth'(prod_ff[i]) * FullWidth'(cfg.gain[i]);
         num_in[i] = full[FullWidth-1:GainFrac];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_chan.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
      if (en1) ratio_ff <= ratio_in;
      if (en2) begin
         prod_ff <= prod_in;
         den2_ff <= den2_in;
         fwd2_ff <= fwd2_in;
      end
      if (en3) begin
         num_ff <= num_in;
         den3_ff <= den2_ff;
         fwd3_ff <= fwd2_ff;
      end
   end

   assign job_valid = v3_ff;
   assign job.num = num_ff;
   assign job.den = den3_ff;
   assign job.fwd = fwd3_ff;
endmodule

// ----- rtl/mwm_queue.sv -----
// Two-entry queue between the front pipeline and the divider.
module mwm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  mwm_pkg::job_type push_job,
   output logic             pop_valid,
   input  logic             pop_ready,
   output mwm_pkg::job_type pop_job
);
   import mwm_pkg::*;

   job_type slot_ff [2];
   logic wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign push_ready = cnt_ff != 2'd2;
   assign pop_valid = cnt_ff != 2'd0;
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;
   assign pop_job = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) slot_ff[wr_ff] <= push_job;
   end
endmodule

// ----- rtl/mwm_back.sv -----
// Back end: four-lane restoring divider, two quotient bits a cycle, result register.
module mwm_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  mwm_pkg::job_type job,
   mwm_rsp_if.source        rsp_chan
);
   import mwm_pkg::*;

   localparam logic [2:0] StepDone = 3'd4;

   logic busy_ff;
   logic [2:0] cnt_ff;
   logic [WheelCount-1:0][NumWidth-1:0] rem_ff, rem_in;
   logic [WheelCount-1:0][SpeedWidth-1:0] quo_ff, quo_in;
   logic [WheelCount-1:0] sat_ff, fwd_ff, osat;
   logic [MagWidth-1:0] den_ff;
   logic out_valid_ff;
   logic [WheelCount-1:0][SpeedWidth-1:0] out_spd_ff;
   logic [WheelCount-1:0] out_fwd_ff;
   logic out_free, finish, load;
   logic [2:0] bit_hi, bit_lo;
   logic [NumWidth-1:0] r;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign finish = busy_ff && (cnt_ff == StepDone) && out_free;
   assign job_ready = !busy_ff || finish;
   assign load = job_valid && job_ready;

   always_comb begin
      bit_hi = 3'd7 - {cnt_ff[1:0], 1'b0};
      bit_lo = 3'd6 - {cnt_ff[1:0], 1'b0};
      for (int i = 0; i < WheelCount; i++) begin
         r = rem_ff[i];
         quo_in[i] = quo_ff[i];
         if (r >= (NumWidth'(den_ff) << bit_hi)) begin
            r = r - (NumWidth'(den_ff) << bit_hi);
            quo_in[i][bit_hi] = 1'b1;
         end
         if (r >= (NumWidth'(den_ff) << bit_lo)) begin
            r = r - (NumWidth'(den_ff) << bit_lo);
            quo_in[i][bit_lo] = 1'b1;
         end
         rem_in[i] = r;
         osat[i] = job.num[i] >= (NumWidth'(job.den) << SpeedWidth);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            busy_ff <= 1'b1;
            cnt_ff <= 3'd0;
         end else if (finish) begin
            busy_ff <= 1'b0;
         end else if (busy_ff && cnt_ff != StepDone) begin
            cnt_ff <= cnt_ff + 3'd1;
         end
         if (finish) out_valid_ff <= 1'b1;
         else if (rsp_chan.ready) out_valid_ff <= 1'b0;
      end
      if (load) begin
         rem_ff <= job.num;
         quo_ff <= '0;
         den_ff <= job.den;
         sat_ff <= osat;
         fwd_ff <= job.fwd;
      end else if (busy_ff && cnt_ff != StepDone) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (finish) begin
         for (int i = 0; i < WheelCount; i++) begin
            out_spd_ff[i] <= sat_ff[i] ? SpeedMax : quo_ff[i];
         end
         out_fwd_ff <= fwd_ff;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.fl_speed = out_spd_ff[0];
   assign rsp_chan.fl_forward = out_fwd_ff[0];
   assign rsp_chan.fr_speed = out_spd_ff[1];
   assign rsp_chan.fr_forward = out_fwd_ff[1];
   assign rsp_chan.rl_speed = out_spd_ff[2];
   assign rsp_chan.rl_forward = out_fwd_ff[2];
   assign rsp_chan.rr_speed = out_spd_ff[3];
   assign rsp_chan.rr_forward = out_fwd_ff[3];

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= StepDone) else $error("divider step count out of range");
   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      load |=> busy_ff && cnt_ff == 3'd0) else $error("load did not start divider");
   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      finish |=> out_valid_ff) else $error("finished result not presented");
   a_no_early_load: assert property (@(posedge clock) disable iff (reset)
      (load && busy_ff) |-> cnt_ff == StepDone) else $error("load while dividing");
endmodule

// ----- rtl/mecanum_wheel_mixer_unit.sv -----
// Top level of the mecanum wheel mixer: registers, front pipeline, queue, divider.
//
//   channel   direction  contents
//   req_chan  in         vel_x, vel_y, turn_rate (signed Q2.13)
//   rsp_chan  out        speed and forward bit for each of the four wheels
//   csr_*     in         write-only registers: scale and four wheel gains
//
// A request passes three front stages (mix, magnitude/max/scale, gain multiply)
// and waits in a two-entry queue; the divider then works through 4 steps of two
// quotient bits and hands the result over, taking the next request only as it
// hands over the last, which sets the rate. Reset is synchronous and restores
// the register defaults; a stalled response holds while the front keeps filling.
module mecanum_wheel_mixer_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   mwm_req_if.sink                              req_chan,
   mwm_rsp_if.source                            rsp_chan,
   input  logic                                 csr_we,
   input  logic [mwm_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [mwm_pkg::CsrDataWidth-1:0]     csr_wdata
);
   import mwm_pkg::*;

   cfg_type cfg_ff;
   logic fq_valid, fq_ready, qb_valid, qb_ready;
   job_type fq_job, qb_job;

   // Register writes; unknown indexes drop, wide values keep their low bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale <= ScaleReset;
         for (int i = 0; i < WheelCount; i++) begin
            cfg_ff.gain[i] <= GainReset;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SPEED_SCALE: cfg_ff.scale <= csr_wdata[ScaleWidth-1:0];
            CSR_GAIN_FL:     cfg_ff.gain[0] <= csr_wdata[GainWidth-1:0];
            CSR_GAIN_FR:     cfg_ff.gain[1] <= csr_wdata[GainWidth-1:0];
            CSR_GAIN_RL:     cfg_ff.gain[2] <= csr_wdata[GainWidth-1:0];
            CSR_GAIN_RR:     cfg_ff.gain[3] <= csr_wdata[GainWidth-1:0];
            default: ;
         endcase
      end
   end

   mwm_front u_front (
      .clock, .reset, .req_chan, .cfg(cfg_ff),
      .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
   );

   mwm_queue u_queue (
      .clock, .reset,
      .push_valid(fq_valid), .push_ready(fq_ready), .push_job(fq_job),
      .pop_valid(qb_valid), .pop_ready(qb_ready), .pop_job(qb_job)
   );

   mwm_back u_back (
      .clock, .reset,
      .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job), .rsp_chan
   );
endmodule
